>>> rtl/core/bms_pkg.sv
// Shared types, widths and helpers for the bitmap store.
`default_nettype none

package bms_pkg;

    localparam int KIND_W       = 2;
    localparam int INDEX_W      = 12;
    localparam int SIZE_W       = 13;
    localparam int BYTE_W       = 8;
    localparam int DEF_MAX_BITS = 4096;

    localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET  = 2'd0,
        KIND_GET  = 2'd1,
        KIND_TEST = 2'd2,
        KIND_FILL = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_TEST,
        ST_FILL
    } state_t;

    // Mask of the low n bits of a byte, n in 1..7.
    function automatic logic [BYTE_W-1:0] low_mask(input logic [2:0] n);
        logic [BYTE_W:0] wide;
        wide     = (9'd1 << n) - 9'd1;
        low_mask = wide[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bms_ram.sv
// Byte-wide single-port-write, registered-read memory holding the bit map.
`default_nettype none

module bms_ram #(
    parameter int DEPTH  = (bms_pkg::DEF_MAX_BITS + 7) / 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [bms_pkg::BYTE_W-1:0] rd_data,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [bms_pkg::BYTE_W-1:0] wr_data
);
    import bms_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/bitmap_store.sv
// Top level of the bitmap store: command channel, size register and op sequencer.
//
// Usage:
//  - Commands: drive kind/index/value with start; a transaction is taken at
//    a rising edge with start high and busy low. kind selects set bit, get
//    bit, test-all-equal or fill.
//  - Results: one per command, shown for exactly one cycle with done high
//    (status, bit_read, all_equal). The receiver cannot stall; results are
//    never held.
//  - Config: cfg_valid/cfg_ready/cfg_data write logical_size. A size above
//    MAX_BITS is dropped. Write only while no command is in flight.
//  - Operation: set and get are a read-modify-write of one byte in the map
//    memory (registered read): the byte is read at the accept edge, then
//    modified and, for set, written back in ACCESS, from which done is
//    registered; no new command is taken until the sequencer is back in idle.
//    Test and fill walk one byte per cycle over the N = ceil(logical_size/8) used bytes.
//  - Reset: logical_size returns to MAX_BITS and the memory is cleared by a
//    pass over all (MAX_BITS+7)/8 bytes (512 at the default) with busy high;
//    config transactions are taken during that pass.
`default_nettype none

module bitmap_store #(
    parameter int MAX_BITS = bms_pkg::DEF_MAX_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [bms_pkg::KIND_W-1:0]  kind,
    input  wire logic [bms_pkg::INDEX_W-1:0] index,
    input  wire logic                        value,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bms_pkg::SIZE_W-1:0]  cfg_data,
    output logic                             done,
    output logic                             status,
    output logic                             bit_read,
    output logic                             all_equal
);
    import bms_pkg::*;

    localparam int MAP_BYTES = (MAX_BITS + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int FULL_W    = SIZE_W - 3;   // whole bytes below size
    localparam int CNT_W     = FULL_W + 1;   // bytes touched, incl. partial one

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

    // FSM and control
    state_t               state_reg, state_next;
    logic [SIZE_W-1:0]    size_reg;
    kind_t                kind_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic                 value_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 cmp_pend_reg, cmp_pend_next;
    logic                 cmp_last_reg, cmp_last_next;
    logic                 acc_reg, acc_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;

    // registered result
    logic                 done_reg, status_reg, bit_read_reg, all_equal_reg;
    logic                 res_valid, res_status, res_bit, res_all;

    // memory port
    logic                 mem_rd_en, mem_wr_en;
    logic [ADDR_W-1:0]    mem_rd_addr, mem_wr_addr;
    logic [BYTE_W-1:0]    mem_rd_data, mem_wr_data;

    // derived from size and the latched command
    logic [FULL_W-1:0]    full_bytes;
    logic [2:0]           part_bits;
    logic [CNT_W-1:0]     n_bytes;
    logic                 walk_more;
    logic                 in_range;
    logic                 accept;
    logic                 cfg_take;
    logic [BYTE_W-1:0]    fill_byte;
    logic [BYTE_W-1:0]    bit_sel;
    logic [BYTE_W-1:0]    cmp_mask;
    logic                 cmp_ok;

    assign full_bytes = size_reg[SIZE_W-1:3];
    assign part_bits  = size_reg[2:0];
    assign n_bytes    = {1'b0, full_bytes} + CNT_W'(part_bits != 3'd0);
    assign walk_more  = (cnt_reg != n_bytes);
    assign in_range   = ({1'b0, index_reg} < size_reg);
    assign fill_byte  = value_reg ? BYTE_ONES : BYTE_ZEROS;
    assign bit_sel    = BYTE_W'(1) << index_reg[2:0];
    assign cmp_mask   = cmp_last_reg ? low_mask(part_bits) : BYTE_ONES;
    assign cmp_ok     = (((mem_rd_data ^ fill_byte) & cmp_mask) == BYTE_ZEROS);

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);
    assign cfg_take  = cfg_valid && cfg_ready;

    bms_ram #(
        .DEPTH  (MAP_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind_t'(kind))
                        KIND_SET:  state_next = ST_ACCESS;
                        KIND_GET:  state_next = ST_ACCESS;
                        KIND_TEST: state_next = ST_TEST;
                        KIND_FILL: state_next = ST_FILL;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACCESS: state_next = ST_IDLE;
            ST_TEST:
            begin
                if (!walk_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                if (!walk_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs: memory port, walk counters, result
    always_comb
    begin
        mem_rd_en     = 1'b0;
        mem_rd_addr   = ADDR_W'(index[INDEX_W-1:3]);
        mem_wr_en     = 1'b0;
        mem_wr_addr   = ADDR_W'(cnt_reg);
        mem_wr_data   = fill_byte;
        cnt_next      = cnt_reg;
        cmp_pend_next = 1'b0;
        cmp_last_next = 1'b0;
        acc_next      = acc_reg;
        clr_addr_next = clr_addr_reg;
        res_valid     = 1'b0;
        res_status    = 1'b0;
        res_bit       = 1'b0;
        res_all       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = BYTE_ZEROS;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                // fetch the byte for a set/get right away
                mem_rd_en = start;
                cnt_next  = '0;
                acc_next  = 1'b1;
            end
            ST_ACCESS:
            begin
                mem_wr_en   = (kind_reg == KIND_SET) && in_range;
                mem_wr_addr = ADDR_W'(index_reg[INDEX_W-1:3]);
                mem_wr_data = value_reg ? (mem_rd_data | bit_sel)
                                        : (mem_rd_data & ~bit_sel);
                res_valid   = 1'b1;
                res_status  = !in_range;
                res_bit     = (kind_reg == KIND_GET) && in_range &&
                              ((mem_rd_data & bit_sel) != BYTE_ZEROS);
            end
            ST_TEST:
            begin
                // reads issued one byte ahead of the compare
                mem_rd_en     = walk_more;
                mem_rd_addr   = ADDR_W'(cnt_reg);
                cnt_next      = cnt_reg + CNT_W'(walk_more);
                cmp_pend_next = walk_more;
                cmp_last_next = walk_more && (cnt_reg == {1'b0, full_bytes});
                acc_next      = acc_reg && (!cmp_pend_reg || cmp_ok);
                res_valid     = !walk_more;
                res_all       = acc_next;
            end
            ST_FILL:
            begin
                mem_wr_en = walk_more;
                cnt_next  = cnt_reg + CNT_W'(walk_more);
                res_valid = !walk_more;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            size_reg      <= SIZE_W'(MAX_BITS);
            clr_addr_reg  <= '0;
            cmp_pend_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cmp_pend_reg <= cmp_pend_next;
            done_reg     <= res_valid;
            if (cfg_take && (32'(cfg_data) <= 32'(MAX_BITS)))
            begin
                size_reg <= cfg_data;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(kind);
            index_reg <= index;
            value_reg <= value;
        end
        cnt_reg       <= cnt_next;
        cmp_last_reg  <= cmp_last_next;
        acc_reg       <= acc_next;
        status_reg    <= res_status;
        bit_read_reg  <= res_bit;
        all_equal_reg <= res_all;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign bit_read  = bit_read_reg;
    assign all_equal = all_equal_reg;

    // A result only follows a cycle of real work.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) != ST_IDLE && $past(state_reg) != ST_CLEAR))
        else $error("result strobe without a command in flight");

    // Walk counter stays within the used bytes.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST || state_reg == ST_FILL) |-> (cnt_reg <= n_bytes))
        else $error("walk counter past last used byte");

    // An accepted command always leaves idle.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // A rejected index reports nothing else.
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (!bit_read && !all_equal))
        else $error("rejected transaction carries data");

    // A rejected set never touches the map.
    a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS && !in_range) |-> !mem_wr_en)
        else $error("write on out-of-range index");

endmodule

`default_nettype wire
